[hdl/tkv_pkg.sv]
`timescale 1ns / 1ps
// Package for the text record key/value parser: transaction structs, label table,
// character codes and the small helper functions shared by the parser modules.
// No dependencies.
package tkv_pkg;

   // Sizing
   localparam int KEY_CHARS  = 8;
   localparam int VALUE_BITS = 32;
   localparam int KEY_LEN_W  = $clog2(KEY_CHARS + 1);
   localparam int KEY_IDX_W  = $clog2(KEY_CHARS);
   localparam int ACC_W      = VALUE_BITS;
   localparam int PROD_W     = VALUE_BITS + 5;
   localparam int VAL_W      = VALUE_BITS + 1;
   localparam int EXT_W      = (VAL_W > 32) ? VAL_W : 32;
   localparam int INDEX_W    = 5;
   localparam int NUM_LABELS = 19;
   localparam int LABEL_CHARS = 16;
   localparam int LABEL_W    = LABEL_CHARS * 8;

   localparam logic [INDEX_W-1:0] PID_INDEX     = INDEX_W'(15);
   localparam logic [INDEX_W-1:0] UNKNOWN_INDEX = INDEX_W'(NUM_LABELS);

   // Largest magnitude: 2^(VALUE_BITS-1)
   localparam logic [ACC_W-1:0] MAG_LIMIT = {1'b1, {(ACC_W - 1){1'b0}}};

   // Character codes
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_VT    = 8'h0b;
   localparam logic [7:0] CHAR_FF    = 8'h0c;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPX   = 8'h58;
   localparam logic [7:0] CHAR_LOWX  = 8'h78;

   localparam logic [4:0] NO_DIGIT = 5'd16;

   // Label table; text is right aligned, last character in the low byte
   localparam logic [LABEL_W-1:0] LABEL_TEXT [NUM_LABELS] = '{
      LABEL_W'("V"), LABEL_W'("VPV"), LABEL_W'("PPV"), LABEL_W'("I"), LABEL_W'("IL"),
      LABEL_W'("LOAD"), LABEL_W'("Relay"), LABEL_W'("H19"), LABEL_W'("H20"),
      LABEL_W'("H21"), LABEL_W'("H22"), LABEL_W'("H23"), LABEL_W'("ERR"),
      LABEL_W'("CS"), LABEL_W'("FW"), LABEL_W'("PID"), LABEL_W'("SER#"),
      LABEL_W'("HSDS"), LABEL_W'("Checksum")
   };
   localparam logic [4:0] LABEL_LEN [NUM_LABELS] = '{
      5'd1, 5'd3, 5'd3, 5'd1, 5'd2, 5'd4, 5'd5, 5'd3, 5'd3, 5'd3,
      5'd3, 5'd3, 5'd3, 5'd2, 5'd2, 5'd3, 5'd4, 5'd4, 5'd8
   };

   // Number conversion phases
   typedef enum logic [2:0] {
      PH_BLANK  = 3'd0,
      PH_SIGN   = 3'd1,
      PH_DIGITS = 3'd2,
      PH_STOP   = 3'd3,
      PH_ZERO   = 3'd4,
      PH_HEX    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_OCT = 2'd1,
      BASE_HEX = 2'd2,
      BASE_PID = 2'd3
   } base_type;

   typedef logic [KEY_CHARS-1:0][7:0] key_chars_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_end;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] field_index;
      logic signed [31:0] field_value;
      logic               value_saturated;
      logic               last_of_block;
   } rsp_type;

   // Control from the top level sequencer to the key and number units
   typedef struct packed {
      logic key_write;
      logic num_start;
      logic start_pid;
      logic num_step;
      logic clear;
   } ctrl_type;

   // Hex-range digit value of a character, NO_DIGIT if none
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] d;
      d = NO_DIGIT;
      if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61) + 5'd10;
      else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41) + 5'd10;
      return d;
   endfunction

   // Parallel compare of the gathered key against all labels, first hit wins
   function automatic logic [INDEX_W-1:0] key_index(input key_chars_type key,
                                                   input logic [KEY_LEN_W-1:0] len,
                                                   input logic too_long);
      logic [INDEX_W-1:0] idx;
      logic               hit;
      logic [3:0]         pos;
      idx = UNKNOWN_INDEX;
      for (int i = NUM_LABELS - 1; i >= 0; i--) begin
         hit = (6'(LABEL_LEN[i]) == 6'(len)) && (int'(LABEL_LEN[i]) <= KEY_CHARS);
         for (int j = 0; j < KEY_CHARS; j++) begin
            if (j < int'(LABEL_LEN[i])) begin
               pos = 4'(LABEL_LEN[i] - 5'(j) - 5'd1);
               if (key[j] != LABEL_TEXT[i][pos*8 +: 8]) hit = 1'b0;
            end
         end
         if (hit) idx = INDEX_W'(i);
      end
      if (too_long) idx = UNKNOWN_INDEX;
      return idx;
   endfunction

endpackage

[hdl/tkv_key_unit.sv]
`timescale 1ns / 1ps
// Key gathering registers and the parallel label match.
// Depends on tkv_pkg.
module tkv_key_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  tkv_pkg::ctrl_type              ctrl,
   input  logic [7:0]                     key_char,
   output logic [tkv_pkg::INDEX_W-1:0]    key_index
);

   tkv_pkg::key_chars_type               key_chars_ff;
   logic [tkv_pkg::KEY_LEN_W-1:0]        key_length_ff, key_length_in;
   logic                                 key_too_long_ff, key_too_long_in;
   logic                                 room;

   assign room = (int'(key_length_ff) < tkv_pkg::KEY_CHARS);

   // Length and overflow flag
   always_comb begin
      key_length_in   = key_length_ff;
      key_too_long_in = key_too_long_ff;
      if (ctrl.clear) begin
         key_length_in   = '0;
         key_too_long_in = 1'b0;
      end else if (ctrl.key_write) begin
         if (room) key_length_in = key_length_ff + 1'b1;
         else key_too_long_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff   <= '0;
         key_too_long_ff <= 1'b0;
      end else begin
         key_length_ff   <= key_length_in;
         key_too_long_ff <= key_too_long_in;
      end
   end

   // Character store; only bytes below the length are ever compared
   always_ff @(posedge clock) begin
      if (ctrl.key_write && !ctrl.clear && room) begin
         key_chars_ff[key_length_ff[tkv_pkg::KEY_IDX_W-1:0]] <= key_char;
      end
   end

   assign key_index = tkv_pkg::key_index(key_chars_ff, key_length_ff, key_too_long_ff);

endmodule

[hdl/tkv_num_unit.sv]
`timescale 1ns / 1ps
// On-the-fly value conversion (atol, or strtol base 0 for the PID key) with
// saturation, and the signed result value. Depends on tkv_pkg.
module tkv_num_unit (
   input  logic               clock,
   input  logic               reset,
   input  tkv_pkg::ctrl_type  ctrl,
   input  logic [7:0]         value_char,
   output logic signed [31:0] field_value,
   output logic               value_saturated
);

   logic [tkv_pkg::ACC_W-1:0]  accum_ff, accum_in;
   logic                       negative_ff, negative_in;
   logic                       overflow_ff, overflow_in;
   tkv_pkg::phase_type         phase_ff, phase_in;
   tkv_pkg::base_type          base_ff, base_in;

   logic [4:0]                 dval;
   logic [4:0]                 acc_digit;
   tkv_pkg::base_type          acc_base;
   logic                       acc_do;
   logic [tkv_pkg::PROD_W-1:0] prod;
   logic [tkv_pkg::PROD_W-1:0] acc_wide;

   assign dval     = tkv_pkg::digit_value(value_char);
   assign acc_wide = tkv_pkg::PROD_W'(accum_ff);

   // Per-character conversion step
   always_comb begin
      accum_in    = accum_ff;
      negative_in = negative_ff;
      overflow_in = overflow_ff;
      phase_in    = phase_ff;
      base_in     = base_ff;
      acc_do      = 1'b0;
      acc_digit   = dval;
      acc_base    = tkv_pkg::BASE_DEC;
      prod        = '0;

      case (phase_ff)
         tkv_pkg::PH_BLANK, tkv_pkg::PH_SIGN: begin
            if (phase_ff == tkv_pkg::PH_BLANK && (value_char == tkv_pkg::CHAR_SPACE ||
                value_char == tkv_pkg::CHAR_VT || value_char == tkv_pkg::CHAR_FF)) begin
               phase_in = phase_ff;
            end else if (phase_ff == tkv_pkg::PH_BLANK && (value_char == tkv_pkg::CHAR_PLUS ||
                         value_char == tkv_pkg::CHAR_MINUS)) begin
               negative_in = (value_char == tkv_pkg::CHAR_MINUS);
               phase_in    = tkv_pkg::PH_SIGN;
            end else if (base_ff == tkv_pkg::BASE_PID && value_char == tkv_pkg::CHAR_ZERO) begin
               base_in  = tkv_pkg::BASE_OCT;
               phase_in = tkv_pkg::PH_ZERO;
            end else if (dval < 5'd10) begin
               if (base_ff == tkv_pkg::BASE_PID) base_in = tkv_pkg::BASE_DEC;
               acc_do   = 1'b1;
               phase_in = tkv_pkg::PH_DIGITS;
            end else begin
               phase_in = tkv_pkg::PH_STOP;
            end
         end
         tkv_pkg::PH_DIGITS: begin
            acc_base = base_ff;
            if ((base_ff == tkv_pkg::BASE_OCT && dval < 5'd8) ||
                (base_ff == tkv_pkg::BASE_HEX && dval < 5'd16) ||
                (base_ff != tkv_pkg::BASE_OCT && base_ff != tkv_pkg::BASE_HEX &&
                 dval < 5'd10)) begin
               acc_do = 1'b1;
            end else begin
               phase_in = tkv_pkg::PH_STOP;
            end
         end
         tkv_pkg::PH_ZERO: begin
            acc_base = tkv_pkg::BASE_OCT;
            if (value_char == tkv_pkg::CHAR_LOWX || value_char == tkv_pkg::CHAR_UPX) begin
               phase_in = tkv_pkg::PH_HEX;
            end else if (dval < 5'd8) begin
               acc_do   = 1'b1;
               phase_in = tkv_pkg::PH_DIGITS;
            end else begin
               phase_in = tkv_pkg::PH_STOP;
            end
         end
         tkv_pkg::PH_HEX: begin
            acc_base = tkv_pkg::BASE_HEX;
            if (dval < 5'd16) begin
               base_in  = tkv_pkg::BASE_HEX;
               acc_do   = 1'b1;
               phase_in = tkv_pkg::PH_DIGITS;
            end else begin
               phase_in = tkv_pkg::PH_STOP;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      // Multiply-add by 8, 10 or 16 as shifts, clamp at the magnitude limit
      case (acc_base)
         tkv_pkg::BASE_OCT: prod = (acc_wide << 3) + tkv_pkg::PROD_W'(acc_digit);
         tkv_pkg::BASE_HEX: prod = (acc_wide << 4) + tkv_pkg::PROD_W'(acc_digit);
         default:           prod = (acc_wide << 3) + (acc_wide << 1) +
                                   tkv_pkg::PROD_W'(acc_digit);
      endcase
      if (acc_do && !overflow_ff) begin
         if (prod > tkv_pkg::PROD_W'(tkv_pkg::MAG_LIMIT)) begin
            accum_in    = tkv_pkg::MAG_LIMIT;
            overflow_in = 1'b1;
         end else begin
            accum_in = prod[tkv_pkg::ACC_W-1:0];
         end
      end

      if (!ctrl.num_step) begin
         accum_in    = accum_ff;
         negative_in = negative_ff;
         overflow_in = overflow_ff;
         phase_in    = phase_ff;
         base_in     = base_ff;
      end
      if (ctrl.clear || ctrl.num_start) begin
         accum_in    = '0;
         negative_in = 1'b0;
         overflow_in = 1'b0;
         phase_in    = tkv_pkg::PH_BLANK;
         base_in     = (ctrl.num_start && !ctrl.clear && ctrl.start_pid) ?
                       tkv_pkg::BASE_PID : tkv_pkg::BASE_DEC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff    <= '0;
         negative_ff <= 1'b0;
         overflow_ff <= 1'b0;
         phase_ff    <= tkv_pkg::PH_BLANK;
         base_ff     <= tkv_pkg::BASE_DEC;
      end else begin
         accum_ff    <= accum_in;
         negative_ff <= negative_in;
         overflow_ff <= overflow_in;
         phase_ff    <= phase_in;
         base_ff     <= base_in;
      end
   end

   // Signed result with clamping of the positive side
   logic [tkv_pkg::ACC_W-1:0]        mag;
   logic signed [tkv_pkg::VAL_W-1:0] val;
   logic signed [tkv_pkg::EXT_W-1:0] val_ext;

   always_comb begin
      mag             = (accum_ff > tkv_pkg::MAG_LIMIT) ? tkv_pkg::MAG_LIMIT : accum_ff;
      value_saturated = overflow_ff;
      if (negative_ff) begin
         val = -$signed({1'b0, mag});
      end else if (mag >= tkv_pkg::MAG_LIMIT) begin
         val             = $signed({1'b0, tkv_pkg::MAG_LIMIT - 1'b1});
         value_saturated = 1'b1;
      end else begin
         val = $signed({1'b0, mag});
      end
      val_ext     = tkv_pkg::EXT_W'(val);
      field_value = val_ext[31:0];
   end

endmodule

[hdl/text_record_key_value_parser.sv]
`timescale 1ns / 1ps
// Text record key/value parser, top level. Depends on tkv_pkg, tkv_key_unit, tkv_num_unit.
// Throughput: one byte per cycle while req_stall is low; the parse state updates at the accepting edge.
// A CR or end-of-block transaction shows its result in the cycle after acceptance,
// held in the result register; input stalls only while that register is full and stalled.
// Reset (synchronous, active high) returns to key collection with no result pending.
module text_record_key_value_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tkv_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tkv_pkg::rsp_type  rsp_data
);

   logic                              req_fire;
   logic                              emit;
   logic                              in_value_ff, in_value_in;
   tkv_pkg::ctrl_type                 ctrl;
   logic [tkv_pkg::INDEX_W-1:0]       key_index;
   logic signed [31:0]                num_value;
   logic                              num_saturated;
   logic                              rsp_valid_ff, rsp_valid_in;
   tkv_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   // Byte decode
   always_comb begin
      ctrl        = '0;
      emit        = 1'b0;
      in_value_in = in_value_ff;
      if (req_fire) begin
         if (req_data.block_end || req_data.data_byte == tkv_pkg::CHAR_CR) begin
            emit        = 1'b1;
            ctrl.clear  = 1'b1;
            in_value_in = 1'b0;
         end else if (req_data.data_byte == tkv_pkg::CHAR_LF) begin
            in_value_in = in_value_ff;
         end else if (!in_value_ff) begin
            if (req_data.data_byte == tkv_pkg::CHAR_TAB) begin
               ctrl.num_start = 1'b1;
               ctrl.start_pid = (key_index == tkv_pkg::PID_INDEX);
               in_value_in    = 1'b1;
            end else begin
               ctrl.key_write = 1'b1;
            end
         end else begin
            ctrl.num_step = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) in_value_ff <= 1'b0;
      else in_value_ff <= in_value_in;
   end

   tkv_key_unit u_key (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .key_char  (req_data.data_byte),
      .key_index (key_index)
   );

   tkv_num_unit u_num (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .value_char      (req_data.data_byte),
      .field_value     (num_value),
      .value_saturated (num_saturated)
   );

   // Result register
   always_comb begin
      rsp_valid_in                = emit || (rsp_valid_ff && rsp_stall);
      rsp_data_in                 = rsp_data_ff;
      if (emit) begin
         rsp_data_in.field_index     = key_index;
         rsp_data_in.field_value     = num_value;
         rsp_data_in.value_saturated = num_saturated;
         rsp_data_in.last_of_block   = req_data.block_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result only appears after a CR or end-of-block transaction
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire && (req_data.block_end ||
                                    req_data.data_byte == tkv_pkg::CHAR_CR)))
      else $error("result without a closing transaction");

   // Closing a pair always returns to key collection
   a_close_state: assert property (@(posedge clock) disable iff (reset)
      emit |=> !in_value_ff)
      else $error("value mode kept after a result");

   // Index stays within the label range
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.field_index <= tkv_pkg::UNKNOWN_INDEX)
      else $error("field index out of range");

endmodule

[dv/text_record_key_value_parser_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for text_record_key_value_parser: a scripted opening then random text
// records, checked against a behavioral parser of its own. Depends on tkv_pkg and the RTL.
module text_record_key_value_parser_tb;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int HOLD_CYCLES = 400;
   localparam int SCRIPT_ROWS = 28;

   typedef enum int {
      MODE_FREE, MODE_SEND_GAPS, MODE_RECV_STALL, MODE_BOTH_GAPS, MODE_BACKPRESSURE
   } run_mode_type;

   // One scripted transaction; fixed rows carry their expected pair typed in
   typedef struct packed {
      logic [7:0]  ch;
      logic        fin;
      logic        fixed;
      logic [4:0]  idx;
      logic [31:0] val;
      logic        sat;
      logic        last;
   } script_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   tkv_pkg::req_type req_data  = '0;
   logic             req_stall;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tkv_pkg::rsp_type rsp_data;

   text_record_key_value_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   string label_names [tkv_pkg::NUM_LABELS] = '{
      "V", "VPV", "PPV", "I", "IL", "LOAD", "Relay", "H19", "H20", "H21", "H22", "H23",
      "ERR", "CS", "FW", "PID", "SER#", "HSDS", "Checksum"
   };

   // Opening script: flushes, LF skip, TAB stopping a value, CR before TAB,
   // PID with a bare 0x, NUL bytes overrunning the key buffer
   script_row_type script [SCRIPT_ROWS] = '{
      '{8'hff, 1'b1, 1'b1, tkv_pkg::UNKNOWN_INDEX, 32'd0, 1'b0, 1'b1},
      '{"V",               1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{tkv_pkg::CHAR_LF,  1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{tkv_pkg::CHAR_TAB, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{"1",               1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{tkv_pkg::CHAR_TAB, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{"3",               1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{tkv_pkg::CHAR_CR,  1'b0, 1'b1, 5'd0, 32'd1, 1'b0, 1'b0},
      '{"I",               1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{tkv_pkg::CHAR_CR,  1'b0, 1'b1, 5'd3, 32'd0, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b1, tkv_pkg::UNKNOWN_INDEX, 32'd0, 1'b0, 1'b1},
      '{"P",               1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{"I",               1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{"D",               1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{tkv_pkg::CHAR_TAB, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{"0",               1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{"x",               1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{tkv_pkg::CHAR_CR,  1'b0, 1'b1, tkv_pkg::PID_INDEX, 32'd0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 5'd0, 32'd0, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b1, tkv_pkg::UNKNOWN_INDEX, 32'd0, 1'b0, 1'b1}
   };

   // Shared run control
   run_mode_type     run_mode      = MODE_FREE;
   int               send_gap_pct  = 0;
   int               recv_hold_pct = 0;
   int               mismatches    = 0;
   int unsigned      cycle_count   = 0;
   tkv_pkg::rsp_type expected_pairs [$];
   tkv_pkg::req_type record_bytes [$];

   // Behavioral parser state
   logic                pr_in_value;
   logic [7:0]          pr_key [tkv_pkg::KEY_CHARS];
   int                  pr_key_len;
   logic                pr_too_long;
   logic [63:0]         pr_accum;
   logic                pr_negative;
   tkv_pkg::phase_type  pr_phase;
   tkv_pkg::base_type   pr_base;
   logic                pr_overflow;

   function automatic void clear_parse();
      pr_in_value = 1'b0;
      foreach (pr_key[i]) pr_key[i] = 8'h00;
      pr_key_len  = 0;
      pr_too_long = 1'b0;
      pr_accum    = '0;
      pr_negative = 1'b0;
      pr_phase    = tkv_pkg::PH_BLANK;
      pr_base     = tkv_pkg::BASE_DEC;
      pr_overflow = 1'b0;
   endfunction

   // First label whose text equals the gathered key
   function automatic logic [4:0] lookup_label();
      bit same;
      if (pr_too_long) return tkv_pkg::UNKNOWN_INDEX;
      for (int i = 0; i < tkv_pkg::NUM_LABELS; i++) begin
         if (label_names[i].len() == pr_key_len &&
             label_names[i].len() <= tkv_pkg::KEY_CHARS) begin
            same = 1'b1;
            for (int j = 0; j < pr_key_len; j++)
               if (label_names[i][j] != pr_key[j]) same = 1'b0;
            if (same) return 5'(i);
         end
      end
      return tkv_pkg::UNKNOWN_INDEX;
   endfunction

   // Digit value of c in the given radix, 16 when it is not a digit there
   function automatic int char_digit(input logic [7:0] c, input int radix);
      int d;
      d = 16;
      if (c >= "0" && c <= "9") d = int'(c) - int'("0");
      else if (c >= "a" && c <= "f") d = int'(c) - int'("a") + 10;
      else if (c >= "A" && c <= "F") d = int'(c) - int'("A") + 10;
      return (d < radix) ? d : 16;
   endfunction

   // Magnitude grows until it passes 2^31, then sticks there
   function automatic void add_digit(input int d, input int radix);
      logic [63:0] lim;
      lim = 64'h8000_0000;
      if (pr_overflow) return;
      if (pr_accum > (lim - 64'(d)) / 64'(radix)) begin
         pr_accum    = lim;
         pr_overflow = 1'b1;
      end else begin
         pr_accum = pr_accum * 64'(radix) + 64'(d);
      end
   endfunction

   function automatic void value_char(input logic [7:0] c);
      int d;
      int radix;
      case (pr_phase)
         tkv_pkg::PH_BLANK, tkv_pkg::PH_SIGN: begin
            if (pr_phase == tkv_pkg::PH_BLANK && (c == tkv_pkg::CHAR_SPACE ||
                c == tkv_pkg::CHAR_VT || c == tkv_pkg::CHAR_FF)) begin
               // leading blanks are skipped
            end else if (pr_phase == tkv_pkg::PH_BLANK && (c == tkv_pkg::CHAR_PLUS ||
                         c == tkv_pkg::CHAR_MINUS)) begin
               pr_negative = (c == tkv_pkg::CHAR_MINUS);
               pr_phase    = tkv_pkg::PH_SIGN;
            end else if (pr_base == tkv_pkg::BASE_PID && c == tkv_pkg::CHAR_ZERO) begin
               pr_base  = tkv_pkg::BASE_OCT;
               pr_phase = tkv_pkg::PH_ZERO;
            end else begin
               d = char_digit(c, 10);
               if (d < 16) begin
                  if (pr_base == tkv_pkg::BASE_PID) pr_base = tkv_pkg::BASE_DEC;
                  add_digit(d, 10);
                  pr_phase = tkv_pkg::PH_DIGITS;
               end else begin
                  pr_phase = tkv_pkg::PH_STOP;
               end
            end
         end
         tkv_pkg::PH_DIGITS: begin
            radix = (pr_base == tkv_pkg::BASE_OCT) ? 8 :
                    ((pr_base == tkv_pkg::BASE_HEX) ? 16 : 10);
            d = char_digit(c, radix);
            if (d < 16) add_digit(d, radix);
            else pr_phase = tkv_pkg::PH_STOP;
         end
         tkv_pkg::PH_ZERO: begin
            if (c == tkv_pkg::CHAR_LOWX || c == tkv_pkg::CHAR_UPX) begin
               pr_phase = tkv_pkg::PH_HEX;
            end else begin
               d = char_digit(c, 8);
               if (d < 16) begin
                  add_digit(d, 8);
                  pr_phase = tkv_pkg::PH_DIGITS;
               end else begin
                  pr_phase = tkv_pkg::PH_STOP;
               end
            end
         end
         tkv_pkg::PH_HEX: begin
            d = char_digit(c, 16);
            if (d < 16) begin
               pr_base = tkv_pkg::BASE_HEX;
               add_digit(d, 16);
               pr_phase = tkv_pkg::PH_DIGITS;
            end else begin
               pr_phase = tkv_pkg::PH_STOP;
            end
         end
         default: ;
      endcase
   endfunction

   // Build the pair for the current key and value, then start over
   function automatic tkv_pkg::rsp_type close_pair(input logic last);
      tkv_pkg::rsp_type res;
      logic [63:0]      lim;
      logic [63:0]      mag;
      logic [63:0]      v;
      logic             sat;
      lim = 64'h8000_0000;
      mag = pr_accum;
      sat = pr_overflow;
      if (mag > lim) mag = lim;
      if (pr_negative) begin
         v = 64'd0 - mag;
      end else begin
         if (mag >= lim) begin
            mag = lim - 64'd1;
            sat = 1'b1;
         end
         v = mag;
      end
      res.field_index     = lookup_label();
      res.field_value     = v[31:0];
      res.value_saturated = sat;
      res.last_of_block   = last;
      clear_parse();
      return res;
   endfunction

   // Advance the parser by one accepted byte; returns 1 when a pair is due
   function automatic bit parse_byte(input tkv_pkg::req_type item,
                                     output tkv_pkg::rsp_type res);
      logic [7:0] c;
      res = '0;
      c   = item.data_byte;
      if (item.block_end) begin
         res = close_pair(1'b1);
         return 1'b1;
      end
      if (c == tkv_pkg::CHAR_CR) begin
         res = close_pair(1'b0);
         return 1'b1;
      end
      if (c == tkv_pkg::CHAR_LF) return 1'b0;
      if (!pr_in_value) begin
         if (c == tkv_pkg::CHAR_TAB) begin
            pr_in_value = 1'b1;
            pr_phase    = tkv_pkg::PH_BLANK;
            pr_base     = (lookup_label() == tkv_pkg::PID_INDEX) ?
                          tkv_pkg::BASE_PID : tkv_pkg::BASE_DEC;
            pr_accum    = '0;
            pr_negative = 1'b0;
            pr_overflow = 1'b0;
         end else if (pr_key_len < tkv_pkg::KEY_CHARS) begin
            pr_key[pr_key_len] = c;
            pr_key_len++;
         end else begin
            pr_too_long = 1'b1;
         end
         return 1'b0;
      end
      value_char(c);
      return 1'b0;
   endfunction

   // Offer one transaction, with random gaps ahead of it, and log its outcome on acceptance
   task automatic send_txn(input tkv_pkg::req_type item, input bit fixed,
                           input tkv_pkg::rsp_type want);
      tkv_pkg::rsp_type pred;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (parse_byte(item, pred)) expected_pairs.push_back(fixed ? want : pred);
   endtask

   task automatic queue_byte(input logic [7:0] c, input logic fin);
      tkv_pkg::req_type item;
      item.data_byte = c;
      item.block_end = fin;
      record_bytes.push_back(item);
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
   endtask

   // One random record: mostly key TAB value CR, sometimes noise or a broken line
   task automatic build_record();
      int          roll;
      int          n;
      logic [7:0]  c;
      logic [63:0] wide;
      string       txt;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         n = $urandom_range(1, 6);
         repeat (n) queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         return;
      end

      // key: known label, PID often, or random bytes that may overrun the buffer
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         queue_text("PID");
      end else if (roll < 75) begin
         queue_text(label_names[$urandom_range(0, tkv_pkg::NUM_LABELS - 1)]);
      end else begin
         n = $urandom_range(0, 12);
         repeat (n) begin
            c = 8'($urandom_range(0, 255));
            if (c == tkv_pkg::CHAR_TAB || c == tkv_pkg::CHAR_CR || c == tkv_pkg::CHAR_LF)
               c = "Z";
            queue_byte(c, 1'b0);
         end
      end
      if ($urandom_range(0, 19) == 0) queue_byte(tkv_pkg::CHAR_LF, 1'b0);
      if ($urandom_range(0, 19) != 0) queue_byte(tkv_pkg::CHAR_TAB, 1'b0);

      // blanks and sign
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            n = $urandom_range(0, 2);
            queue_byte((n == 0) ? tkv_pkg::CHAR_SPACE :
                       ((n == 1) ? tkv_pkg::CHAR_VT : tkv_pkg::CHAR_FF), 1'b0);
         end
      end
      roll = $urandom_range(0, 9);
      if (roll < 2) queue_byte(tkv_pkg::CHAR_MINUS, 1'b0);
      else if (roll < 3) queue_byte(tkv_pkg::CHAR_PLUS, 1'b0);

      // number text
      case ($urandom_range(0, 6))
         0: queue_text($sformatf("%0d", $urandom_range(0, 99999)));
         1: queue_text($sformatf("%0d", $urandom()));
         2: begin
            case ($urandom_range(0, 5))
               0: txt = "2147483647";
               1: txt = "2147483648";
               2: txt = "2147483649";
               3: txt = "4294967295";
               4: txt = "4294967296";
               default: txt = "99999999999";
            endcase
            queue_text(txt);
         end
         3: repeat ($urandom_range(10, 20))
               queue_byte(tkv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
         4: begin
            wide = {$urandom(), $urandom()} >> $urandom_range(0, 63);
            txt  = $sformatf("%0h", wide);
            if ($urandom_range(0, 1) == 1) txt = txt.toupper();
            queue_text(($urandom_range(0, 1) == 1) ? "0x" : "0X");
            if ($urandom_range(0, 4) != 0) queue_text(txt);
         end
         5: begin
            wide = {$urandom(), $urandom()} >> $urandom_range(0, 63);
            queue_byte(tkv_pkg::CHAR_ZERO, 1'b0);
            if ($urandom_range(0, 3) != 0) queue_text($sformatf("%0o", wide));
         end
         default: ;
      endcase

      // trailing junk after the number
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            c = 8'($urandom_range(0, 255));
            if (c == tkv_pkg::CHAR_CR) c = tkv_pkg::CHAR_TAB;
            queue_byte(c, 1'b0);
         end
      end

      if ($urandom_range(0, 99) < 85) queue_byte(tkv_pkg::CHAR_CR, 1'b0);
      else queue_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic run_records(input run_mode_type mode, input int items, input int gap_pct,
                              input int hold_pct);
      int               sent;
      tkv_pkg::req_type item;
      run_mode      = mode;
      send_gap_pct  = gap_pct;
      recv_hold_pct = hold_pct;
      sent = 0;
      while (sent < items) begin
         build_record();
         while (record_bytes.size() != 0) begin
            item = record_bytes.pop_front();
            send_txn(item, 1'b0, '0);
            if (item.block_end || item.data_byte != tkv_pkg::CHAR_LF) sent++;
         end
      end
   endtask

   // Receiver: random stalls, plus one long hold-off in the backpressure phase
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (run_mode == MODE_BACKPRESSURE && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_hold_pct);
      end
   end

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Compare each accepted pair with the oldest expected one
   always @(posedge clock) begin : pair_check
      tkv_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pairs.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual index %0d value %0d",
                     $time, rsp_data.field_index, rsp_data.field_value);
            mismatches++;
         end else begin
            want = expected_pairs.pop_front();
            check_field("field_index", want.field_index, rsp_data.field_index);
            check_field("field_value", want.field_value, rsp_data.field_value);
            check_field("value_saturated", want.value_saturated, rsp_data.value_saturated);
            check_field("last_of_block", want.last_of_block, rsp_data.last_of_block);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Main sequence
   initial begin : main_flow
      tkv_pkg::req_type item;
      tkv_pkg::rsp_type want;
      clear_parse();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // scripted opening, no gaps
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         item.data_byte        = script[i].ch;
         item.block_end        = script[i].fin;
         want.field_index      = script[i].idx;
         want.field_value      = script[i].val;
         want.value_saturated  = script[i].sat;
         want.last_of_block    = script[i].last;
         send_txn(item, script[i].fixed, want);
      end

      run_records(MODE_FREE,         280, 0,  0);
      run_records(MODE_SEND_GAPS,    280, 53, 0);
      run_records(MODE_RECV_STALL,   280, 0,  53);
      run_records(MODE_BOTH_GAPS,    280, 35, 35);
      run_records(MODE_BACKPRESSURE, 200, 0,  0);
      req_valid <= 1'b0;

      // drain, then wait briefly for any stray transaction
      while (expected_pairs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
